[design/sspd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspd_pkg: shared definitions for the servo status packet deframer
// Constants, configuration register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sspd_pkg;

    localparam int PARAM_DEPTH_DEF = 32;
    localparam int RESULT_CAP      = 32;
    localparam int BYTE_W          = 8;
    localparam int CNT_W           = 6;
    localparam int CFG_DATA_W      = 8;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COPY_LIMIT  = 1'd1;

    localparam logic [CNT_W-1:0] COPY_LIMIT_RESET = 6'd32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hc_clear;
        logic hc_count;
        logic id_load;
        logic sum_add;
        logic len_load;
        logic idx_clear;
        logic param_write;
        logic emit_load;
        logic rd_issue;
        logic out_load;
        logic k_step;
    } cmd_t;

    // Conditions reported back by the datapath.
    typedef struct packed {
        logic hdr_full;
        logic len_ok;
        logic pe_zero;
        logic idx_done;
        logic csum_ok;
        logic emit_none;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

[design/sspd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspd_ctrl: packet parsing and drain sequencer
// Walks the header, length, error, parameter and checksum phases, then
// steps through the buffered parameters to emit the results.
// ----------------------------------------------------------------------------
module sspd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             line_gap,
    output logic             in_stall,
    input  sspd_pkg::status_t sts,
    output sspd_pkg::cmd_t   cmd
);

    localparam logic [2:0] ST_HUNT     = 3'd0;
    localparam logic [2:0] ST_LEN      = 3'd1;
    localparam logic [2:0] ST_ERR      = 3'd2;
    localparam logic [2:0] ST_ERR_DROP = 3'd3;
    localparam logic [2:0] ST_PARAM    = 3'd4;
    localparam logic [2:0] ST_CSUM     = 3'd5;
    localparam logic [2:0] ST_DRAIN_RD = 3'd6;
    localparam logic [2:0] ST_DRAIN_OUT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       draining;
    logic       in_acc;

    assign draining = (state_reg == ST_DRAIN_RD) || (state_reg == ST_DRAIN_OUT);
    assign in_stall = draining;
    assign in_acc   = in_valid && !draining;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_acc && !line_gap)
                begin
                    if (sts.hdr_full)
                    begin
                        cmd.id_load  = 1'b1;
                        cmd.hc_clear = 1'b1;
                        state_next   = ST_LEN;
                    end
                    else
                    begin
                        cmd.hc_count = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                if (in_acc)
                begin
                    if (line_gap)
                    begin
                        cmd.hc_clear = 1'b1;
                        state_next   = ST_HUNT;
                    end
                    else
                    begin
                        cmd.sum_add  = 1'b1;
                        cmd.len_load = sts.len_ok;
                        state_next   = sts.len_ok ? ST_ERR : ST_ERR_DROP;
                    end
                end
            end
            ST_ERR:
            begin
                if (in_acc)
                begin
                    if (line_gap)
                    begin
                        cmd.hc_clear = 1'b1;
                        state_next   = ST_HUNT;
                    end
                    else
                    begin
                        cmd.sum_add   = 1'b1;
                        cmd.idx_clear = 1'b1;
                        state_next    = sts.pe_zero ? ST_CSUM : ST_PARAM;
                    end
                end
            end
            ST_ERR_DROP:
            begin
                if (in_acc)
                begin
                    cmd.hc_clear = 1'b1;
                    state_next   = ST_HUNT;
                end
            end
            ST_PARAM:
            begin
                if (in_acc)
                begin
                    if (line_gap)
                    begin
                        cmd.hc_clear = 1'b1;
                        state_next   = ST_HUNT;
                    end
                    else
                    begin
                        cmd.param_write = 1'b1;
                        cmd.sum_add     = 1'b1;
                        if (sts.idx_done)
                        begin
                            state_next = ST_CSUM;
                        end
                    end
                end
            end
            ST_CSUM:
            begin
                if (in_acc)
                begin
                    cmd.hc_clear = 1'b1;
                    if (!line_gap && sts.csum_ok)
                    begin
                        cmd.emit_load = 1'b1;
                        state_next    = ST_DRAIN_RD;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DRAIN_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.emit_none || sts.emit_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.k_step = 1'b1;
                        state_next = ST_DRAIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/sspd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspd_datapath: registers, parameter buffer and result register
// Holds the header count, id, length, running sum, parameter buffer,
// configuration registers and the output register of the deframer.
// ----------------------------------------------------------------------------
module sspd_datapath
#(
    parameter int PARAM_DEPTH = sspd_pkg::PARAM_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sspd_pkg::BYTE_W-1:0]        rx_byte,
    input  logic                               cfg_we,
    input  logic [sspd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sspd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  sspd_pkg::cmd_t                     cmd,
    output sspd_pkg::status_t                  sts,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [sspd_pkg::BYTE_W-1:0]        param_byte,
    output logic                               byte_valid,
    output logic [sspd_pkg::CNT_W-1:0]         param_count,
    output logic                               last
);

    localparam int CW = $clog2(PARAM_DEPTH + 1);
    localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
    localparam int SW = 9;

    logic [sspd_pkg::BYTE_W-1:0] param_mem [PARAM_DEPTH];

    logic [1:0]                       hc_reg;
    logic [sspd_pkg::BYTE_W-1:0]      id_reg;
    logic [sspd_pkg::BYTE_W-1:0]      sum_reg;
    logic [CW-1:0]                    pe_reg;
    logic [CW-1:0]                    idx_reg;
    logic [sspd_pkg::CNT_W-1:0]       n_reg;
    logic [sspd_pkg::CNT_W-1:0]       k_reg;
    logic [sspd_pkg::BYTE_W-1:0]      rd_data_reg;
    logic [sspd_pkg::BYTE_W-1:0]      exp_id_reg;
    logic [sspd_pkg::CNT_W-1:0]       copy_limit_reg;
    logic                             out_valid_reg;
    logic [sspd_pkg::BYTE_W-1:0]      out_byte_reg;
    logic                             out_bv_reg;
    logic [sspd_pkg::CNT_W-1:0]       out_cnt_reg;
    logic                             out_last_reg;

    logic [SW-1:0]                    pe_w;
    logic [SW-1:0]                    lim_w;
    logic [SW-1:0]                    n_w;
    logic [CW:0]                      idx_inc;

    assign pe_w    = SW'(pe_reg);
    assign lim_w   = SW'(copy_limit_reg);
    assign idx_inc = (CW + 1)'(idx_reg) + 1'b1;

    // Number of results: smallest of the count, the copy limit and the cap.
    always_comb
    begin
        n_w = pe_w;
        if (lim_w < n_w)
        begin
            n_w = lim_w;
        end
        if (SW'(sspd_pkg::RESULT_CAP) < n_w)
        begin
            n_w = SW'(sspd_pkg::RESULT_CAP);
        end
    end

    always_comb
    begin
        sts.hdr_full  = (hc_reg >= 2'd2);
        sts.len_ok    = (rx_byte >= 8'd2) &&
                        ({1'b0, rx_byte} <= SW'(PARAM_DEPTH + 2));
        sts.pe_zero   = (pe_reg == '0);
        sts.idx_done  = (idx_inc >= (CW + 1)'(pe_reg));
        sts.csum_ok   = ((~sum_reg) == rx_byte) && (id_reg == exp_id_reg);
        sts.emit_none = (n_reg == '0);
        sts.emit_last = ((k_reg + 1'b1) == n_reg);
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    // Parameter buffer and its registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.param_write)
        begin
            param_mem[AW'(idx_reg)] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= param_mem[AW'(k_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg         <= '0;
            id_reg         <= '0;
            sum_reg        <= '0;
            pe_reg         <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            exp_id_reg     <= '0;
            copy_limit_reg <= sspd_pkg::COPY_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.hc_clear)
            begin
                hc_reg <= '0;
            end
            else if (cmd.hc_count)
            begin
                hc_reg <= (rx_byte == sspd_pkg::HDR_BYTE) ? hc_reg + 2'd1 : 2'd0;
            end
            if (cmd.id_load)
            begin
                id_reg  <= rx_byte;
                sum_reg <= rx_byte;
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_reg + rx_byte;
            end
            if (cmd.len_load)
            begin
                pe_reg <= CW'(rx_byte - 8'd2);
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.param_write)
            begin
                idx_reg <= CW'(idx_inc);
            end
            if (cmd.emit_load)
            begin
                n_reg <= sspd_pkg::CNT_W'(n_w);
                k_reg <= '0;
            end
            else if (cmd.k_step)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sspd_pkg::CFG_EXPECTED_ID: exp_id_reg     <= cfg_data;
                    sspd_pkg::CFG_COPY_LIMIT:  copy_limit_reg <= cfg_data[sspd_pkg::CNT_W-1:0];
                    default:                   exp_id_reg     <= exp_id_reg;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; an empty packet gives a zero byte marked not valid.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_byte_reg <= (n_reg == '0) ? '0 : rd_data_reg;
            out_bv_reg   <= (n_reg != '0);
            out_cnt_reg  <= sspd_pkg::CNT_W'(pe_reg);
            out_last_reg <= (n_reg == '0) || ((k_reg + 1'b1) == n_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign param_byte  = out_byte_reg;
    assign byte_valid  = out_bv_reg;
    assign param_count = out_cnt_reg;
    assign last        = out_last_reg;

endmodule

[design/servo_status_packet_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_packet_deframer_core: status packet deframer for a servo bus
// Finds the two-byte header, reads id, length and error bytes, buffers the
// parameters and checks the inverted checksum; good packets for the chosen
// id are passed on one parameter byte per item.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid / in_stall | rx_byte, line_gap
//  output   | out_valid/out_stall | param_byte, byte_valid, param_count, last
//  config   | cfg_we              | cfg_index, cfg_data
//
//  While parsing, one received item is taken in every cycle.
//  A packet that passes its checks is drained from the parameter buffer one
//  result at a time (buffer read, then output register load), through the
//  single registered read port of the buffer; input is stalled meanwhile.
//  The output register lets the next item be accepted while the last result
//  of a packet still waits to be taken.
//  Reset is asynchronous and active low and returns the parser to hunting.
//
module servo_status_packet_deframer_core
#(
    parameter int PARAM_DEPTH = sspd_pkg::PARAM_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sspd_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                             line_gap,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sspd_pkg::BYTE_W-1:0]      param_byte,
    output logic                             byte_valid,
    output logic [sspd_pkg::CNT_W-1:0]       param_count,
    output logic                             last,
    input  logic                             cfg_we,
    input  logic [sspd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sspd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // The controller sequences the phases; the datapath holds every value.
    sspd_pkg::cmd_t    cmd;
    sspd_pkg::status_t sts;

    sspd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .line_gap (line_gap),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sspd_datapath
    #(
        .PARAM_DEPTH (PARAM_DEPTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .param_byte  (param_byte),
        .byte_valid  (byte_valid),
        .param_count (param_count),
        .last        (last)
    );

endmodule
